// File: sv/multinomial_coefficient_four_assert.svh
// Assertion macros for the checker file.
`ifndef MULTINOMIAL_COEFFICIENT_FOUR_ASSERT_SVH
`define MULTINOMIAL_COEFFICIENT_FOUR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcf check failed");

// Next-cycle implication, disabled while reset is held.
`define MCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcf check failed");

`endif

// File: sv/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg
// Types and constants for the four-count multinomial coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcf_pkg;

  localparam int CountW       = 8;
  localparam int CountMaxDef  = 255;
  localparam int BaseW        = 10;   // n - k of one binomial, up to 3 * 255
  localparam int KW           = CountW;
  localparam int IdxW         = KW + 1;
  localparam int CoefW        = 63;
  localparam int ProdW        = CoefW + BaseW;
  localparam int CntW         = $clog2(ProdW);
  localparam int NumSeg       = 3;

  localparam logic [CoefW-1:0] CoefMax = '1;

  typedef struct packed {
    logic [CountW-1:0] count_a;
    logic [CountW-1:0] count_c;
    logic [CountW-1:0] count_g;
    logic [CountW-1:0] count_t;
  } item_t;

  typedef struct packed {
    logic [CoefW-1:0] coefficient;
    logic             overflow;
  } result_t;

  // One item as three binomial chains: C(base + k, k) each
  typedef struct packed {
    logic [NumSeg-1:0][BaseW-1:0] base;
    logic [NumSeg-1:0][KW-1:0]    k;
  } job_t;

  typedef enum logic [1:0] {
    SEG_AC  = 2'd0,
    SEG_G   = 2'd1,
    SEG_T   = 2'd2,
    SEG_BAD = 2'd3
  } seg_e;

endpackage

`default_nettype wire

// File: sv/multinomial_coefficient_four.sv
// Multinomial coefficient (a+c+g+t)!/(a!c!g!t!) of four 8-bit counts, exact,
// saturated to 2^63-1 with the overflow flag set when it does not fit. The
// value is built as one running product over three binomial chains; each
// step multiplies by (base + i) and divides exactly by i with a bit-serial
// divider. An item stops at the first step whose value exceeds the limit.
// A two-entry queue takes new items while the back end works, and one
// finished result waits in an output register.
// ----------------------------------------------------------------------------
// multinomial_coefficient_four
// Top level: front classifier, job queue and sequential back end.
// ----------------------------------------------------------------------------
`default_nettype none

module multinomial_coefficient_four import mcf_pkg::*; #(
  parameter int COUNT_MAX = CountMaxDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  job_t job_in, job_out;
  logic job_valid, job_pop;

  mcf_front #(.COUNT_MAX(COUNT_MAX)) u_front (
    .item_i (item_i),
    .job_o  (job_in)
  );

  mcf_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (job_in),
    .full_o    (full),
    .rd_i      (job_pop),
    .valid_o   (job_valid),
    .rd_data_o (job_out)
  );

  mcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// File: sv/mcf_front.sv
// ----------------------------------------------------------------------------
// mcf_front
// Clamps the counts and splits an item into three binomial chains.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_front import mcf_pkg::*; #(
  parameter int COUNT_MAX = CountMaxDef
) (
  input  item_t item_i,
  output job_t  job_o
);

  logic [CountW-1:0] a, c, g, t;
  logic [BaseW-1:0]  n1, n2, ga, ta;

  function automatic logic [CountW-1:0] clamp(input logic [CountW-1:0] v);
    clamp = (32'(v) > COUNT_MAX) ? CountW'(COUNT_MAX) : v;
  endfunction

  // clamp each count
  assign a = clamp(item_i.count_a);
  assign c = clamp(item_i.count_c);
  assign g = clamp(item_i.count_g);
  assign t = clamp(item_i.count_t);

  assign ga = BaseW'(g);
  assign ta = BaseW'(t);
  assign n1 = BaseW'(a) + BaseW'(c);
  assign n2 = n1 + ga;

  // use the shorter side of each binomial: k = min, base = max
  always_comb begin
    job_o.k[SEG_AC]    = (a < c) ? a : c;
    job_o.base[SEG_AC] = (a < c) ? BaseW'(c) : BaseW'(a);
    job_o.k[SEG_G]     = (ga <= n1) ? g : n1[KW-1:0];
    job_o.base[SEG_G]  = (ga <= n1) ? n1 : ga;
    job_o.k[SEG_T]     = (ta <= n2) ? t : n2[KW-1:0];
    job_o.base[SEG_T]  = (ta <= n2) ? n2 : ta;
  end

endmodule

`default_nettype wire

// File: sv/mcf_fifo.sv
// ----------------------------------------------------------------------------
// mcf_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_fifo import mcf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  job_t  wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  valid_o,
  output job_t  rd_data_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= !wr_ptr_q;
      if (do_rd) rd_ptr_q <= !rd_ptr_q;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

// File: sv/mcf_back.sv
// ----------------------------------------------------------------------------
// mcf_back
// Runs the binomial chains: per step one multiply by (base + i), then an
// exact bit-serial divide by i. Holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_back import mcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_valid_i,
  input  job_t    job_i,
  output logic    job_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t result_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  job_t              job_q, job_d;
  seg_e              seg_q, seg_d;
  logic [IdxW-1:0]   i_q, i_d;
  logic [CoefW-1:0]  r_q, r_d;
  logic              ovf_q, ovf_d;
  logic [ProdW-1:0]  quo_q, quo_d;
  logic [IdxW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [KW-1:0]     cur_k;
  logic [BaseW-1:0]  cur_base, mult;
  logic [IdxW:0]     rem_sh;
  logic              ge;

  // current chain
  always_comb begin
    unique case (seg_q)
      SEG_AC:  begin cur_k = job_q.k[SEG_AC]; cur_base = job_q.base[SEG_AC]; end
      SEG_G:   begin cur_k = job_q.k[SEG_G];  cur_base = job_q.base[SEG_G];  end
      SEG_T:   begin cur_k = job_q.k[SEG_T];  cur_base = job_q.base[SEG_T];  end
      default: begin cur_k = '0;              cur_base = '0;                 end
    endcase
  end

  assign mult   = cur_base + BaseW'(i_q);
  assign rem_sh = {rem_q, quo_q[ProdW-1]};
  assign ge     = (rem_sh >= {1'b0, i_q});

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    seg_d       = seg_q;
    i_d         = i_q;
    r_d         = r_q;
    ovf_d       = ovf_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_d   = job_i;
          seg_d   = SEG_AC;
          i_d     = IdxW'(1);
          r_d     = CoefW'(1);
          ovf_d   = 1'b0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (i_q > {1'b0, cur_k}) begin
          // chain finished, move to the next one
          if (seg_q == SEG_T) begin
            state_d = S_DONE;
          end else begin
            seg_d = seg_e'(seg_q + 2'd1);
            i_d   = IdxW'(1);
          end
        end else begin
          quo_d   = ProdW'(r_q) * ProdW'(mult);
          rem_d   = '0;
          cnt_d   = CntW'(ProdW - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        rem_d = ge ? IdxW'(rem_sh - {1'b0, i_q}) : rem_sh[IdxW-1:0];
        quo_d = {quo_q[ProdW-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          if (quo_d[ProdW-1:CoefW] != '0) begin
            ovf_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            r_d     = quo_d[CoefW-1:0];
            i_d     = i_q + IdxW'(1);
            state_d = S_STEP;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || pop_i) begin
          out_d.coefficient = ovf_q ? CoefMax : r_q;
          out_d.overflow    = ovf_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    seg_q <= seg_d;
    i_q   <= i_d;
    r_q   <= r_d;
    ovf_q <= ovf_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// File: sv/mcf_checker.sv
// ----------------------------------------------------------------------------
// mcf_checker
// Port-level checks on the result side of the block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multinomial_coefficient_four_assert.svh"

module mcf_checker import mcf_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    full,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t result_o
);

  // a saturated result carries the all-ones value
  `MCF_ASSERT_NOW(a_ovf_sat, !empty && result_o.overflow, result_o.coefficient == CoefMax)

  // a coefficient is never zero
  `MCF_ASSERT_NOW(a_nonzero, !empty && !result_o.overflow, result_o.coefficient != '0)

  // a waiting result holds until its transfer
  `MCF_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(result_o))

  // handshake status outputs are always known out of reset
  `MCF_ASSERT_NOW(a_known, 1'b1, !$isunknown({full, empty}))

endmodule

bind multinomial_coefficient_four mcf_checker u_chk (.*);

`default_nettype wire
